>>> rtl/stpm_pkg.sv
// ----------------------------------------------------------------------------
// stpm_pkg
// types, codes and sizes shared by the sorted table with prime marks
// ----------------------------------------------------------------------------
`default_nettype none

package stpm_pkg;

    localparam int Capacity = 64;
    localparam int IdxW     = $clog2(Capacity);
    localparam int CntW     = 7;

    typedef enum logic [2:0] {
        OP_INSERT     = 3'd0,
        OP_REMOVE     = 3'd1,
        OP_READ_ASC   = 3'd2,
        OP_READ_SIDE  = 3'd3,
        OP_READ_PRIME = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRIME,
        S_SHIFT_UP,
        S_SEARCH,
        S_SHIFT_DN,
        S_PSCAN,
        S_READ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] value;
        logic [5:0]  position;
    } in_word_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic [6:0]  entry_count;
        logic [6:0]  prime_count;
        logic        value_is_prime;
        logic [1:0]  status;
    } out_word_t;

endpackage

`default_nettype wire

>>> rtl/stpm_if.sv
// ----------------------------------------------------------------------------
// stpm_if
// valid/ready channel carrying one word of a given type
// ----------------------------------------------------------------------------
`default_nettype none

interface stpm_if #(parameter type word_t = logic) ();
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/sorted_table_with_prime_marks_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_with_prime_marks_unit
// sorted table of signed values with prime marks, one restoring divider
// ----------------------------------------------------------------------------
// channel  dir  word
// in_ch    in   operation, value, position
// out_ch   out  result_value, entry_count, prime_count, value_is_prime, status
//
// insert: prime test with up to ~46340 trial divisors (the divider is
// bit-serial), then larger entries move up one place each; remove: entries
// are searched in order, then those after the match shift down; prime read:
// entries are scanned in order. ascending and side-cross reads read one entry.
// the table memory has one read and one write port, which sets the shift and
// scan costs.
// async active-low reset clears control, the fill count and the prime count only.
// the input is not ready from acceptance until the result word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_with_prime_marks_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    stpm_if.sink      in_ch,
    stpm_if.source    out_ch
);
    import stpm_pkg::*;

    logic [32:0] mem [Capacity];

    state_t      state_reg, state_next;
    in_word_t    req_reg, req_next;
    logic [CntW-1:0] fill_reg, fill_next;
    logic [CntW-1:0] pcnt_reg, pcnt_next;
    logic [CntW-1:0] j_reg, j_next;
    logic [CntW-1:0] seen_reg, seen_next;
    logic        mark_reg, mark_next;
    logic [31:0] res_reg, res_next;
    logic        rprime_reg, rprime_next;
    status_t     st_reg, st_next;
    logic        ovalid_reg, ovalid_next;
    // divider
    logic [31:0] d_reg, d_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] rem_reg, rem_next;
    logic [5:0]  bit_reg, bit_next;
    logic        div_busy_reg, div_busy_next;

    logic [IdxW-1:0] raddr;
    logic [32:0]     rdata;
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [32:0]     wdata;

    logic [32:0] trial;
    logic [63:0] dsq;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            pcnt_reg     <= '0;
            ovalid_reg   <= 1'b0;
            div_busy_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            pcnt_reg     <= pcnt_next;
            ovalid_reg   <= ovalid_next;
            div_busy_reg <= div_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        j_reg      <= j_next;
        seen_reg   <= seen_next;
        mark_reg   <= mark_next;
        res_reg    <= res_next;
        rprime_reg <= rprime_next;
        st_reg     <= st_next;
        d_reg      <= d_next;
        q_reg      <= q_next;
        rem_reg    <= rem_next;
        bit_reg    <= bit_next;
    end

    assign trial = {rem_reg, q_reg[31]} - {1'b0, d_reg};
    assign dsq   = 64'(d_reg) * 64'(d_reg);

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data.result_value   = res_reg;
    assign out_ch.data.entry_count    = fill_reg;
    assign out_ch.data.prime_count    = pcnt_reg;
    assign out_ch.data.value_is_prime = rprime_reg;
    assign out_ch.data.status         = st_reg;

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        fill_next     = fill_reg;
        pcnt_next     = pcnt_reg;
        j_next        = j_reg;
        seen_next     = seen_reg;
        mark_next     = mark_reg;
        res_next      = res_reg;
        rprime_next   = rprime_reg;
        st_next       = st_reg;
        ovalid_next   = ovalid_reg;
        d_next        = d_reg;
        q_next        = q_reg;
        rem_next      = rem_reg;
        bit_next      = bit_reg;
        div_busy_next = div_busy_reg;
        raddr         = j_reg[IdxW-1:0];
        we            = 1'b0;
        waddr         = j_reg[IdxW-1:0];
        wdata         = rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    req_next    = in_ch.data;
                    res_next    = '0;
                    rprime_next = 1'b0;
                    st_next     = ST_OK;
                    seen_next   = '0;
                    j_next      = '0;
                    raddr       = '0;
                    case (op_t'(in_ch.data.operation))
                        OP_INSERT:
                        begin
                            if (fill_reg >= CntW'(Capacity))
                            begin
                                st_next    = ST_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                mark_next     = ~in_ch.data.value[31]
                                                && (in_ch.data.value > 32'd1);
                                d_next        = 32'd2;
                                div_busy_next = 1'b0;
                                state_next    = S_PRIME;
                            end
                        end
                        OP_REMOVE:
                        begin
                            st_next    = ST_NOT_FOUND;
                            state_next = S_SEARCH;
                        end
                        OP_READ_ASC, OP_READ_SIDE:
                        begin
                            if (CntW'(in_ch.data.position) >= fill_reg)
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                if (in_ch.data.operation == OP_READ_SIDE
                                    && in_ch.data.position[0])
                                begin
                                    j_next = fill_reg - 7'd1
                                             - CntW'(in_ch.data.position[5:1]);
                                end
                                else if (in_ch.data.operation == OP_READ_SIDE)
                                begin
                                    j_next = CntW'(in_ch.data.position[5:1]);
                                end
                                else
                                begin
                                    j_next = CntW'(in_ch.data.position);
                                end
                                raddr      = j_next[IdxW-1:0];
                                state_next = S_READ;
                            end
                        end
                        OP_READ_PRIME:
                        begin
                            st_next    = ST_RANGE;
                            state_next = S_PSCAN;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            // trial division: d from 2 while d*d <= n, bit-serial remainder
            S_PRIME:
            begin
                if (!mark_reg)
                begin
                    j_next     = fill_reg;
                    raddr      = fill_reg[IdxW-1:0] - IdxW'(1);
                    state_next = S_SHIFT_UP;
                end
                else if (!div_busy_reg)
                begin
                    if (dsq > 64'(req_reg.value))
                    begin
                        j_next     = fill_reg;
                        raddr      = fill_reg[IdxW-1:0] - IdxW'(1);
                        state_next = S_SHIFT_UP;
                    end
                    else
                    begin
                        q_next        = req_reg.value;
                        rem_next      = '0;
                        bit_next      = '0;
                        div_busy_next = 1'b1;
                    end
                end
                else
                begin
                    q_next = {q_reg[30:0], 1'b0};
                    if (!trial[32])
                    begin
                        rem_next = trial[31:0];
                    end
                    else
                    begin
                        rem_next = {rem_reg[30:0], q_reg[31]};
                    end
                    bit_next = bit_reg + 6'd1;
                    if (bit_reg == 6'd31)
                    begin
                        div_busy_next = 1'b0;
                        if (rem_next == '0)
                        begin
                            mark_next = 1'b0;
                        end
                        d_next = d_reg + 32'd1;
                    end
                end
            end
            // rdata holds entry j-1 (read issued last cycle)
            S_SHIFT_UP:
            begin
                if (j_reg != '0 && $signed(rdata[31:0]) > $signed(req_reg.value))
                begin
                    we     = 1'b1;
                    waddr  = j_reg[IdxW-1:0];
                    wdata  = rdata;
                    j_next = j_reg - 7'd1;
                    raddr  = j_reg[IdxW-1:0] - IdxW'(2);
                end
                else
                begin
                    we          = 1'b1;
                    waddr       = j_reg[IdxW-1:0];
                    wdata       = {mark_reg, req_reg.value};
                    fill_next   = fill_reg + 7'd1;
                    pcnt_next   = pcnt_reg + CntW'(mark_reg);
                    rprime_next = mark_reg;
                    state_next  = S_DONE;
                end
            end
            // read of entry j issued; rdata valid from the next cycle
            S_SEARCH:
            begin
                if (j_reg >= fill_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_SHIFT_DN:
            begin
                // rdata holds entry j+1
                if (j_reg + 7'd1 < fill_reg)
                begin
                    we     = 1'b1;
                    waddr  = j_reg[IdxW-1:0];
                    wdata  = rdata;
                    j_next = j_reg + 7'd1;
                    raddr  = j_reg[IdxW-1:0] + IdxW'(2);
                end
                else
                begin
                    fill_next  = fill_reg - 7'd1;
                    state_next = S_DONE;
                end
            end
            S_PSCAN:
            begin
                if (j_reg >= fill_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                case (op_t'(req_reg.operation))
                    OP_REMOVE:
                    begin
                        if (rdata[31:0] == req_reg.value)
                        begin
                            st_next    = ST_OK;
                            pcnt_next  = pcnt_reg - CntW'(rdata[32]);
                            raddr      = j_reg[IdxW-1:0] + IdxW'(1);
                            state_next = S_SHIFT_DN;
                        end
                        else
                        begin
                            j_next     = j_reg + 7'd1;
                            raddr      = j_reg[IdxW-1:0] + IdxW'(1);
                            state_next = S_SEARCH;
                        end
                    end
                    OP_READ_PRIME:
                    begin
                        if (rdata[32] && seen_reg == CntW'(req_reg.position))
                        begin
                            res_next    = rdata[31:0];
                            rprime_next = 1'b1;
                            st_next     = ST_OK;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            seen_next  = seen_reg + CntW'(rdata[32]);
                            j_next     = j_reg + 7'd1;
                            raddr      = j_reg[IdxW-1:0] + IdxW'(1);
                            state_next = S_PSCAN;
                        end
                    end
                    default:
                    begin
                        res_next    = rdata[31:0];
                        rprime_next = rdata[32];
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_DONE:
            begin
                if (!ovalid_reg)
                begin
                    ovalid_next = 1'b1;
                end
                else if (out_ch.ready)
                begin
                    ovalid_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/stpm_checker.sv
// ----------------------------------------------------------------------------
// stpm_checker
// port-level checks on the sorted table, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module stpm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [6:0]  entry_count,
    input wire logic [6:0]  prime_count,
    input wire logic [1:0]  status,
    input wire logic        value_is_prime
);
    import stpm_pkg::*;

    // no new word taken while a result is pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while result pending");

    // a taken word keeps the input closed on the next cycle
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still ready after a word was taken");

    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (prime_count <= entry_count && entry_count <= 7'(Capacity)))
        else $error("counts out of range");

    a_err_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> !value_is_prime)
        else $error("prime mark on error");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(status))
        else $error("result dropped while stalled");

endmodule

bind sorted_table_with_prime_marks_unit stpm_checker u_stpm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .entry_count    (out_ch.data.entry_count),
    .prime_count    (out_ch.data.prime_count),
    .status         (out_ch.data.status),
    .value_is_prime (out_ch.data.value_is_prime)
);

`default_nettype wire

>>> tb/tb_sorted_table_with_prime_marks_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_table_with_prime_marks_unit
// drives insert, remove and the three read orders through the valid/ready
// channels; a table model in the bench predicts every result word, which is
// compared field by field as it arrives; random gaps on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_table_with_prime_marks_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import stpm_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 64;

    typedef struct {
        logic [2:0]  operation;
        logic [31:0] value;
        logic [5:0]  position;
        bit          typed;
        out_word_t   typed_result;
    } stim_row_t;

    logic clk;
    logic rst_n;

    stpm_if #(.word_t(in_word_t))  in_ch ();
    stpm_if #(.word_t(out_word_t)) out_ch ();

    sorted_table_with_prime_marks_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // bench copy of the table
    int        table_values[$];
    bit        table_marks[$];
    out_word_t pending_results[$];
    int        failures;
    int        items_sent;
    int        cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CycleLimit)
            begin
                $display("%0t timeout with %0d results outstanding", $time,
                         pending_results.size());
                $display("** sorted_table_with_prime_marks_unit: FAILED **");
                $finish;
            end
        end
    end

    function automatic bit is_prime(int v);
        longint unsigned n;
        longint unsigned d;
        if (v < 2)
            return 1'b0;
        n = v;
        for (d = 2; d * d <= n; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int count_marked();
        int c;
        c = 0;
        foreach (table_marks[i])
            c += table_marks[i];
        return c;
    endfunction

    // applies one word to the bench table and returns the word the block owes
    function automatic out_word_t table_apply(in_word_t w);
        out_word_t r;
        int        v;
        int        j;
        int        idx;
        int        seen;
        bit        mark;
        r = '0;
        r.status = ST_OK;
        v = $signed(w.value);
        case (w.operation)
            OP_INSERT:
            begin
                if (table_values.size() >= Capacity)
                    r.status = ST_FULL;
                else
                begin
                    mark = is_prime(v);
                    j = table_values.size();
                    // equal values: new one lands after them
                    while (j > 0 && table_values[j-1] > v)
                        j--;
                    table_values.insert(j, v);
                    table_marks.insert(j, mark);
                    r.value_is_prime = mark;
                end
            end
            OP_REMOVE:
            begin
                r.status = ST_NOT_FOUND;
                foreach (table_values[i])
                begin
                    if (table_values[i] == v)
                    begin
                        table_values.delete(i);
                        table_marks.delete(i);
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            OP_READ_ASC, OP_READ_SIDE:
            begin
                if (w.position >= table_values.size())
                    r.status = ST_RANGE;
                else
                begin
                    idx = w.position;
                    // side-cross: even ranks from the front, odd from the back
                    if (w.operation == OP_READ_SIDE)
                        idx = w.position[0] ? table_values.size() - 1 - (w.position >> 1)
                                            : (w.position >> 1);
                    r.result_value = table_values[idx];
                    r.value_is_prime = table_marks[idx];
                end
            end
            OP_READ_PRIME:
            begin
                r.status = ST_RANGE;
                seen = 0;
                foreach (table_values[i])
                begin
                    if (table_marks[i])
                    begin
                        if (seen == w.position)
                        begin
                            r.result_value = table_values[i];
                            r.value_is_prime = 1'b1;
                            r.status = ST_OK;
                            break;
                        end
                        seen++;
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = 7'(table_values.size());
        r.prime_count = 7'(count_marked());
        return r;
    endfunction

    function automatic int pick_gap(int n);
        int roll;
        // every third stretch of 16 words runs with no gaps
        if ((n / 16) % 3 == 1)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic bit word_differs(string tag, out_word_t e, out_word_t a);
        bit bad;
        bad = 1'b0;
        if (e.result_value !== a.result_value)
        begin
            $display("%0t %s result_value exp %0d got %0d", $time, tag,
                     $signed(e.result_value), $signed(a.result_value));
            bad = 1'b1;
        end
        if (e.entry_count !== a.entry_count)
        begin
            $display("%0t %s entry_count exp %0d got %0d", $time, tag,
                     e.entry_count, a.entry_count);
            bad = 1'b1;
        end
        if (e.prime_count !== a.prime_count)
        begin
            $display("%0t %s prime_count exp %0d got %0d", $time, tag,
                     e.prime_count, a.prime_count);
            bad = 1'b1;
        end
        if (e.value_is_prime !== a.value_is_prime)
        begin
            $display("%0t %s value_is_prime exp %0b got %0b", $time, tag,
                     e.value_is_prime, a.value_is_prime);
            bad = 1'b1;
        end
        if (e.status !== a.status)
        begin
            $display("%0t %s status exp %0d got %0d", $time, tag, e.status, a.status);
            bad = 1'b1;
        end
        return bad;
    endfunction

    task automatic send_word(logic [2:0] op, logic [31:0] v, logic [5:0] pos);
        in_word_t  w;
        out_word_t r;
        int        gap;
        w.operation = op;
        w.value = v;
        w.position = pos;
        gap = pick_gap(items_sent);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        r = table_apply(w);
        pending_results = {pending_results, r};
        items_sent++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 250) - 50;
            1: return $urandom | 32'h8000_0000;
            2: return $urandom & 32'h7fff_fffe;
            // large odd or even multiple of three, quick to rule out
            default: return $urandom_range(1, 715827882) * 3;
        endcase
    endfunction

    function automatic logic [5:0] pick_position(bit prime_rank);
        int span;
        span = prime_rank ? count_marked() : table_values.size();
        if (span > 0 && $urandom_range(0, 9) < 8)
            return 6'($urandom_range(0, span - 1));
        return 6'($urandom_range(0, 63));
    endfunction

    task automatic send_random(int insert_w, int remove_w);
        int        roll;
        logic [31:0] v;
        roll = $urandom_range(0, 99);
        if (roll < insert_w)
            send_word(OP_INSERT, pick_value(), 6'($urandom_range(0, 63)));
        else if (roll < insert_w + remove_w)
        begin
            v = pick_value();
            if (table_values.size() > 0 && $urandom_range(0, 9) < 7)
                v = table_values[$urandom_range(0, table_values.size() - 1)];
            send_word(OP_REMOVE, v, 6'($urandom_range(0, 63)));
        end
        else if (roll < 80)
            send_word(OP_READ_ASC, $urandom, pick_position(1'b0));
        else if (roll < 90)
            send_word(OP_READ_SIDE, $urandom, pick_position(1'b0));
        else if (roll < 96)
            send_word(OP_READ_PRIME, $urandom, pick_position(1'b1));
        else
            send_word(3'($urandom_range(5, 7)), $urandom, 6'($urandom_range(0, 63)));
    endtask

    // result side
    initial
    begin
        int        stall;
        out_word_t e;
        out_ch.ready <= 1'b0;
        stall = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected result word", $time);
                    failures++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (word_differs("result", e, out_ch.data))
                        failures++;
                end
                stall = pick_gap(items_sent);
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    stim_row_t directed_rows[$];

    function automatic stim_row_t row(logic [2:0] op, logic [31:0] v, logic [5:0] pos,
                                      bit typed = 1'b0, logic [1:0] st = ST_OK,
                                      int entries = 0);
        stim_row_t s;
        s.operation = op;
        s.value = v;
        s.position = pos;
        s.typed = typed;
        s.typed_result = '0;
        s.typed_result.status = st;
        s.typed_result.entry_count = 7'(entries);
        return s;
    endfunction

    initial
    begin
        out_word_t predicted;
        stim_row_t s;
        failures = 0;
        items_sent = 0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;

        // empty table, error codes and unused codes have obvious answers
        directed_rows = {
            row(OP_READ_ASC, 32'd0, 6'd0, 1'b1, ST_RANGE, 0),
            row(OP_REMOVE, 32'd5, 6'd0, 1'b1, ST_NOT_FOUND, 0),
            row(OP_READ_PRIME, 32'd0, 6'd0, 1'b1, ST_RANGE, 0),
            row(3'd5, 32'hffff_ffff, 6'd63, 1'b1, ST_OK, 0),
            row(OP_INSERT, 32'h8000_0000, 6'd63, 1'b1, ST_OK, 1),
            row(OP_INSERT, 32'h7fff_fffe, 6'd0),
            row(OP_INSERT, 32'd0, 6'd0),
            row(OP_INSERT, 32'd1, 6'd0),
            row(OP_INSERT, 32'd2, 6'd0),
            row(OP_INSERT, 32'd3, 6'd0),
            row(OP_INSERT, 32'd4, 6'd0),
            row(OP_INSERT, 32'd7, 6'd0),
            row(OP_INSERT, 32'd7, 6'd0),
            row(OP_INSERT, 32'd65521, 6'd0),
            row(OP_INSERT, -32'sd7, 6'd0),
            row(OP_READ_ASC, 32'd0, 6'd0),
            row(OP_READ_ASC, 32'd0, 6'd10),
            row(OP_READ_SIDE, 32'd0, 6'd1),
            row(OP_READ_SIDE, 32'd0, 6'd2),
            row(OP_READ_PRIME, 32'd0, 6'd0),
            row(OP_READ_PRIME, 32'd0, 6'd4),
            row(OP_REMOVE, 32'd7, 6'd0),
            row(OP_REMOVE, 32'h7fff_ffff, 6'd0),
            row(3'd7, 32'd0, 6'd0),
            row(OP_READ_ASC, 32'd0, 6'd63)
        };

        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            s = directed_rows[i];
            send_word(s.operation, s.value, s.position);
            predicted = pending_results[$];
            if (s.typed && word_differs("table row", s.typed_result, predicted))
                failures++;
        end

        repeat (8) send_random(35, 25);
        // fill to capacity, then hit the full case and read the far end
        while (table_values.size() < Capacity)
        begin
            if ($urandom_range(0, 9) < 9)
                send_word(OP_INSERT, pick_value(), 6'($urandom_range(0, 63)));
            else
                send_random(0, 0);
        end
        send_word(OP_INSERT, pick_value(), 6'd0);
        send_word(OP_INSERT, 32'd11, 6'd0);
        send_word(OP_READ_ASC, 32'd0, 6'd63);
        send_word(OP_READ_SIDE, 32'd0, 6'd63);
        repeat (8) send_random(20, 45);

        in_ch.valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (failures == 0)
            $display("** sorted_table_with_prime_marks_unit: PASSED **");
        else
            $display("** sorted_table_with_prime_marks_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/stpm_pkg.sv
rtl/stpm_if.sv
rtl/sorted_table_with_prime_marks_unit.sv
rtl/stpm_checker.sv
tb/tb_sorted_table_with_prime_marks_unit.sv
